// ----- rtl/tte_pkg.sv -----
// Shared constants for the tap tempo estimator.
package tte_pkg;

   localparam int TIME_W      = 32;
   localparam int IVL_W       = 16;
   localparam int TEMPO_W     = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam int WINDOW_LEN_DEF    = 4;
   localparam int MS_PER_MINUTE_DEF = 60000;

   localparam logic [IVL_W-1:0]   TIMEOUT_RESET = 16'd2000;
   localparam logic [TEMPO_W-1:0] TEMPO_MAX     = 8'hFF;

   localparam logic MODE_TAP  = 1'b0;
   localparam logic MODE_STOP = 1'b1;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctrl_type;

endpackage

// ----- rtl/tte_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tte_div #(
   parameter int DVD_W = 20,
   parameter int DSR_W = tte_pkg::IVL_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DVD_W-1:0]            dividend,
   input  logic [DSR_W-1:0]            divisor,
   output tte_pkg::div_ctrl_type       ctrl,
   output logic [DVD_W-1:0]            quotient
);

   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W:0]   trial;
   logic [DSR_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign ctrl.start = start;
   assign ctrl.done  = done_ff;
   assign quotient   = quo_ff;

endmodule

// ----- rtl/tap_tempo_estimator_top.sv -----
// Tap tempo estimator: tap/stop words in, one tempo word out per input word.
//
// Input words (req_) carry a mode bit and a millisecond timestamp; each
// accepted word yields exactly one result word (rsp_) with the measuring
// flag, the tempo of the latest interval and the held WINDOW_LEN-interval
// average tempo, both in beats per minute and saturated to 255.
// A stop word or a starting tap goes straight to the result. A later tap
// stores its interval in the window; once an earlier interval is stored it
// also divides for the tempo of that interval. With a full window the tap
// first sums the window, then stores its interval and divides for the
// average interval, its tempo and the interval tempo, all on the shared
// bit-serial divider, which runs once per tempo and once for the window average.
// One word is processed at a time; the next word can be accepted as soon
// as the result appears. req_ready is high whenever the engine is idle, also
// while a finished result waits in the output register.
// A stalled receiver holds the result; the next word is taken, but its
// result waits until the output register frees.
// Reset clears the measurement, the held average and the result valid flag,
// and sets timeout_ms (register 0, APB byte address 0) to 2000.
module tap_tempo_estimator_top #(
   parameter int WINDOW_LEN    = tte_pkg::WINDOW_LEN_DEF,
   parameter int MS_PER_MINUTE = tte_pkg::MS_PER_MINUTE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [tte_pkg::TIME_W-1:0]        req_tap_time,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_measuring,
   output logic [tte_pkg::TEMPO_W-1:0]       rsp_last_tempo,
   output logic                              rsp_last_valid,
   output logic [tte_pkg::TEMPO_W-1:0]       rsp_average_tempo,
   output logic                              rsp_average_updated,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tte_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [tte_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [tte_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int IVL_W  = tte_pkg::IVL_W;
   localparam int TIME_W = tte_pkg::TIME_W;
   localparam int TW     = tte_pkg::TEMPO_W;
   localparam int QW     = $clog2(MS_PER_MINUTE + 1);
   localparam int SUM_W  = IVL_W + $clog2(WINDOW_LEN);
   localparam int DVD_W  = (QW > SUM_W) ? QW : SUM_W;
   localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
   localparam int STEP_W = $clog2(WINDOW_LEN);
   localparam int ST_W   = 4;

   localparam logic [ST_W-1:0] ST_IDLE       = 4'd0;
   localparam logic [ST_W-1:0] ST_DECIDE     = 4'd1;
   localparam logic [ST_W-1:0] ST_SUM        = 4'd2;
   localparam logic [ST_W-1:0] ST_SHIFT      = 4'd3;
   localparam logic [ST_W-1:0] ST_AVG_GO     = 4'd4;
   localparam logic [ST_W-1:0] ST_AVG_WAIT   = 4'd5;
   localparam logic [ST_W-1:0] ST_TEMPO_GO   = 4'd6;
   localparam logic [ST_W-1:0] ST_TEMPO_WAIT = 4'd7;
   localparam logic [ST_W-1:0] ST_LAST_GO    = 4'd8;
   localparam logic [ST_W-1:0] ST_LAST_WAIT  = 4'd9;
   localparam logic [ST_W-1:0] ST_OUT        = 4'd10;

   logic [ST_W-1:0]   state_ff, state_in;
   logic [IVL_W-1:0]  timeout_ff, timeout_in;
   logic              active_ff, active_in;
   logic [TIME_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TW-1:0]     held_ff, held_in;
   logic              mode_ff, mode_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [IVL_W-1:0]  ivl_ff, ivl_in;
   logic              full_ff, full_in;
   logic              lv_ff, lv_in;
   logic [TW-1:0]     lt_ff, lt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IVL_W-1:0]  avg_ff, avg_in;
   logic [IVL_W-1:0]  win_ff [WINDOW_LEN];
   logic [IVL_W-1:0]  win_in [WINDOW_LEN];

   logic              out_valid_ff, out_valid_in;
   logic              out_meas_ff, out_meas_in;
   logic [TW-1:0]     out_lt_ff, out_lt_in;
   logic              out_lv_ff, out_lv_in;
   logic [TW-1:0]     out_avg_ff, out_avg_in;
   logic              out_au_ff, out_au_in;

   logic [TIME_W-1:0] ivl_full;
   logic              restart;
   logic              csr_write;
   logic              div_start;
   logic [DVD_W-1:0]  div_dividend;
   logic [IVL_W-1:0]  div_divisor;
   logic [DVD_W-1:0]  div_quotient;
   tte_pkg::div_ctrl_type div_ctrl;

   function automatic logic [TW-1:0] sat_tempo(input logic [DVD_W-1:0] q, input logic zero);
      logic [TW-1:0] t;
      t = (|q[DVD_W-1:TW]) ? tte_pkg::TEMPO_MAX : q[TW-1:0];
      return zero ? tte_pkg::TEMPO_MAX : t;
   endfunction

   tte_div #(
      .DVD_W (DVD_W),
      .DSR_W (IVL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .ctrl     (div_ctrl),
      .quotient (div_quotient)
   );

   assign csr_write = psel && penable && pwrite && !paddr[2];
   assign pready    = 1'b1;
   assign prdata    = paddr[2] ? '0 : {{(tte_pkg::CSR_DATA_W - IVL_W){1'b0}}, timeout_ff};
   assign timeout_in = csr_write ? pwdata[IVL_W-1:0] : timeout_ff;

   assign ivl_full = time_ff - prev_ff;
   assign restart  = !active_ff || (ivl_full >= {{(TIME_W - IVL_W){1'b0}}, timeout_ff});

   assign div_start = (state_ff == ST_AVG_GO) || (state_ff == ST_TEMPO_GO)
                      || (state_ff == ST_LAST_GO);

   always_comb begin
      div_dividend = DVD_W'(MS_PER_MINUTE);
      div_divisor  = ivl_ff;
      case (state_ff)
         ST_AVG_GO: begin
            div_dividend = DVD_W'(sum_ff);
            div_divisor  = IVL_W'(WINDOW_LEN);
         end
         ST_TEMPO_GO: begin
            div_divisor = avg_ff;
         end
         default: begin
            div_divisor = ivl_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      prev_in      = prev_ff;
      count_in     = count_ff;
      held_in      = held_ff;
      mode_in      = mode_ff;
      time_in      = time_ff;
      ivl_in       = ivl_ff;
      full_in      = full_ff;
      lv_in        = lv_ff;
      lt_in        = lt_ff;
      sum_in       = sum_ff;
      step_in      = step_ff;
      avg_in       = avg_ff;
      win_in       = win_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_meas_in  = out_meas_ff;
      out_lt_in    = out_lt_ff;
      out_lv_in    = out_lv_ff;
      out_avg_in   = out_avg_ff;
      out_au_in    = out_au_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               time_in  = req_tap_time;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            lt_in   = '0;
            lv_in   = 1'b0;
            full_in = 1'b0;
            if (mode_ff == tte_pkg::MODE_STOP) begin
               active_in = 1'b0;
               state_in  = ST_OUT;
            end else if (restart) begin
               active_in = 1'b1;
               prev_in   = time_ff;
               count_in  = '0;
               state_in  = ST_OUT;
            end else begin
               prev_in = time_ff;
               ivl_in  = ivl_full[IVL_W-1:0];
               lv_in   = (count_ff != '0);
               full_in = (count_ff == CNT_W'(WINDOW_LEN));
               sum_in  = '0;
               step_in = '0;
               state_in = (count_ff == CNT_W'(WINDOW_LEN)) ? ST_SUM : ST_SHIFT;
            end
         end
         ST_SUM: begin
            sum_in = sum_ff + SUM_W'(win_ff[0]);
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[WINDOW_LEN-1] = win_ff[0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(WINDOW_LEN - 1)) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[WINDOW_LEN-1] = ivl_ff;
            if (!full_ff) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (full_ff) begin
               state_in = ST_AVG_GO;
            end else if (lv_ff) begin
               state_in = ST_LAST_GO;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_AVG_GO: begin
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_ctrl.done) begin
               avg_in   = div_quotient[IVL_W-1:0];
               state_in = ST_TEMPO_GO;
            end
         end
         ST_TEMPO_GO: begin
            state_in = ST_TEMPO_WAIT;
         end
         ST_TEMPO_WAIT: begin
            if (div_ctrl.done) begin
               held_in  = sat_tempo(div_quotient, avg_ff == '0);
               state_in = ST_LAST_GO;
            end
         end
         ST_LAST_GO: begin
            state_in = ST_LAST_WAIT;
         end
         ST_LAST_WAIT: begin
            if (div_ctrl.done) begin
               lt_in    = sat_tempo(div_quotient, ivl_ff == '0);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_meas_in  = active_ff;
               out_lt_in    = lt_ff;
               out_lv_in    = lv_ff;
               out_avg_in   = held_ff;
               out_au_in    = full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= tte_pkg::TIMEOUT_RESET;
         active_ff    <= 1'b0;
         prev_ff      <= '0;
         count_ff     <= '0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         active_ff    <= active_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      time_ff     <= time_in;
      ivl_ff      <= ivl_in;
      full_ff     <= full_in;
      lv_ff       <= lv_in;
      lt_ff       <= lt_in;
      sum_ff      <= sum_in;
      step_ff     <= step_in;
      avg_ff      <= avg_in;
      win_ff      <= win_in;
      out_meas_ff <= out_meas_in;
      out_lt_ff   <= out_lt_in;
      out_lv_ff   <= out_lv_in;
      out_avg_ff  <= out_avg_in;
      out_au_ff   <= out_au_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = out_valid_ff;
   assign rsp_measuring       = out_meas_ff;
   assign rsp_last_tempo      = out_lt_ff;
   assign rsp_last_valid      = out_lv_ff;
   assign rsp_average_tempo   = out_avg_ff;
   assign rsp_average_updated = out_au_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW_LEN))
      else $error("stored interval count beyond window length");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.done |-> (state_ff == ST_AVG_WAIT || state_ff == ST_TEMPO_WAIT
                         || state_ff == ST_LAST_WAIT))
      else $error("divider finished outside a wait state");

   a_tempo_needs_measuring: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_valid) |-> (rsp_measuring && !$isunknown(rsp_last_tempo)))
      else $error("tempo word without active measurement");

   a_avg_implies_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_average_updated) |-> rsp_last_valid)
      else $error("average update without interval tempo");
`endif

endmodule
